>>> src/srr_pkg.sv
// ============================================================================
// srr_pkg
// Shared constants, types and the CRC byte step for the selective repeat
// receiver.
// ============================================================================
package srr_pkg;

    localparam int SEQ_BITS    = 16;
    localparam int HOLD_SLOTS  = 4;
    localparam int SLOT_BITS   = $clog2(HOLD_SLOTS);
    localparam int CRC_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 3;
    localparam int MAX_OUT     = 5;
    localparam int MAX_REL     = MAX_OUT - 2;
    localparam int REL_BITS    = $clog2(MAX_REL);
    localparam int AHEAD_W     = 2;
    localparam int BEHIND_W    = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CRC_W-1:0]    CRC_POLY     = 16'h8005;
    localparam logic [SEQ_BITS-1:0] SEQ_MAX      = {SEQ_BITS{1'b1}};
    localparam logic [AHEAD_W-1:0]  AHEAD_RESET  = 2'd3;
    localparam logic [BEHIND_W-1:0] BEHIND_RESET = 4'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_AHEAD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEHIND = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 3'd0,
        KIND_NAK     = 3'd1,
        KIND_IGNORE  = 3'd2,
        KIND_DELIVER = 3'd3,
        KIND_HELD    = 3'd4
    } kind_t;

    typedef struct packed {
        logic                good;
        logic [SEQ_BITS-1:0] seq;
    } pkt_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        logic             top;
        crc = crc_in;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            top = crc[CRC_W-1];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (top ^ data[i])
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

>>> src/srr_front.sv
// ============================================================================
// srr_front
// Folds payload bytes into the running CRC and queues one verdict record
// (CRC good, sequence number) per packet on its last byte.
// ============================================================================
module srr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [srr_pkg::BYTE_W-1:0]    data_byte,
    input  logic [srr_pkg::CRC_W-1:0]     rx_crc,
    input  logic [srr_pkg::SEQ_BITS-1:0]  seq_num,
    input  logic                          last_byte,
    output logic                          push,
    output srr_pkg::pkt_t                 push_pkt,
    input  logic                          q_full
);
    import srr_pkg::*;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_calc;
    logic             accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign crc_calc = crc_byte(crc_reg, data_byte);
    assign push     = accept && last_byte;

    always_comb
    begin
        push_pkt.good = (crc_calc == rx_crc);
        push_pkt.seq  = seq_num;
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (accept)
        begin
            crc_next = last_byte ? '0 : crc_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

>>> src/srr_queue.sv
// ============================================================================
// srr_queue
// Small FIFO of packet verdicts between the CRC front and the window back.
// ============================================================================
module srr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  srr_pkg::pkt_t push_pkt,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output srr_pkg::pkt_t q_pkt
);
    import srr_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    pkt_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_pkt   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

>>> src/srr_back.sv
// ============================================================================
// srr_back
// Window logic: classifies each packet verdict against the expected sequence
// number, tracks held slots, emits results one beat per cycle unless stalled.
// ============================================================================
module srr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  srr_pkg::pkt_t                 q_pkt,
    output logic                          pop,
    input  logic [srr_pkg::AHEAD_W-1:0]   ahead_window,
    input  logic [srr_pkg::BEHIND_W-1:0]  behind_window,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [srr_pkg::KIND_W-1:0]    kind,
    output logic [srr_pkg::SEQ_BITS-1:0]  out_seq,
    output logic [srr_pkg::SLOT_BITS-1:0] slot,
    output logic                          last
);
    import srr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_DELIVER = 3'b010,
        ST_RELEASE = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [SEQ_BITS-1:0]   exp_reg;
    logic [SEQ_BITS-1:0]   exp_next;
    logic [HOLD_SLOTS-1:0] held_reg;
    logic [HOLD_SLOTS-1:0] held_next;
    logic [REL_BITS-1:0]   rel_cnt_reg;
    logic [REL_BITS-1:0]   rel_cnt_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    kind_t                 kind_reg;
    logic [SEQ_BITS-1:0]   seq_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic                  last_reg;

    kind_t                 res_kind;
    logic [SEQ_BITS-1:0]   res_seq;
    logic [SLOT_BITS-1:0]  res_slot;
    logic                  res_last;
    logic                  load;
    logic                  advance;
    logic                  more;

    logic [SEQ_BITS-1:0]   exp_inc;
    logic [SLOT_BITS-1:0]  idx_cur;
    logic [SLOT_BITS-1:0]  idx_inc;
    logic [SLOT_BITS-1:0]  idx_pkt;
    logic [HOLD_SLOTS-1:0] held_clr;
    logic [AHEAD_W-1:0]    eff_ahead;
    logic [SEQ_BITS:0]     seq_w;
    logic [SEQ_BITS:0]     exp_w;
    logic                  is_exp;
    logic                  is_ahead;
    logic                  is_old;

    assign advance = !out_valid_reg || !out_stall;

    assign exp_inc = (exp_reg == SEQ_MAX) ? exp_reg : exp_reg + 1'b1;
    assign idx_cur = exp_reg[SLOT_BITS-1:0];
    assign idx_inc = exp_inc[SLOT_BITS-1:0];
    assign idx_pkt = q_pkt.seq[SLOT_BITS-1:0];

    always_comb
    begin
        held_clr          = held_reg;
        held_clr[idx_cur] = 1'b0;
    end

    assign eff_ahead = (int'(ahead_window) > HOLD_SLOTS - 1) ? AHEAD_W'(HOLD_SLOTS - 1)
                       : ahead_window;
    assign seq_w     = {1'b0, q_pkt.seq};
    assign exp_w     = {1'b0, exp_reg};
    assign is_exp    = (q_pkt.seq == exp_reg);
    assign is_ahead  = (seq_w > exp_w) && (seq_w <= exp_w + (SEQ_BITS + 1)'(eff_ahead));
    assign is_old    = (seq_w < exp_w) && (seq_w + (SEQ_BITS + 1)'(behind_window) >= exp_w);

    always_comb
    begin
        state_next   = state_reg;
        exp_next     = exp_reg;
        held_next    = held_reg;
        rel_cnt_next = rel_cnt_reg;
        pop          = 1'b0;
        load         = 1'b0;
        more         = 1'b0;
        res_kind     = KIND_ACK;
        res_seq      = q_pkt.seq;
        res_slot     = '0;
        res_last     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && advance)
                begin
                    pop  = 1'b1;
                    load = 1'b1;
                    if (!q_pkt.good)
                    begin
                        res_kind = KIND_NAK;
                    end
                    else if (is_exp)
                    begin
                        res_kind   = KIND_ACK;
                        res_last   = 1'b0;
                        state_next = ST_DELIVER;
                    end
                    else if (is_ahead)
                    begin
                        res_kind           = KIND_ACK;
                        held_next[idx_pkt] = 1'b1;
                    end
                    else if (is_old)
                    begin
                        res_kind = KIND_ACK;
                    end
                    else
                    begin
                        res_kind = KIND_IGNORE;
                    end
                end
            end
            ST_DELIVER:
            begin
                if (advance)
                begin
                    load         = 1'b1;
                    res_kind     = KIND_DELIVER;
                    res_seq      = exp_reg;
                    exp_next     = exp_inc;
                    rel_cnt_next = '0;
                    more         = held_reg[idx_inc];
                    res_last     = !more;
                    state_next   = more ? ST_RELEASE : ST_IDLE;
                end
            end
            ST_RELEASE:
            begin
                if (advance)
                begin
                    load         = 1'b1;
                    res_kind     = KIND_HELD;
                    res_seq      = exp_reg;
                    res_slot     = idx_cur;
                    held_next    = held_clr;
                    exp_next     = exp_inc;
                    rel_cnt_next = rel_cnt_reg + 1'b1;
                    more         = (rel_cnt_reg < REL_BITS'(MAX_REL - 1)) && held_clr[idx_inc];
                    res_last     = !more;
                    state_next   = more ? ST_RELEASE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            exp_reg       <= '0;
            held_reg      <= '0;
            rel_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            held_reg      <= held_next;
            rel_cnt_reg   <= rel_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= res_kind;
            seq_reg  <= res_seq;
            slot_reg <= res_slot;
            last_reg <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_seq   = seq_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

    a_release_slot_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RELEASE |-> held_reg[exp_reg[SLOT_BITS-1:0]])
        else $error("release state entered with expected slot not held");

    a_expected_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> exp_reg >= $past(exp_reg))
        else $error("expected sequence number went backwards");

    a_slot_only_on_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_HELD |-> slot_reg == '0)
        else $error("nonzero slot on a result that is not a held delivery");

    a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !pop)
        else $error("queue popped while a packet is still in progress");

    a_release_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RELEASE |-> rel_cnt_reg <= REL_BITS'(MAX_REL - 1))
        else $error("too many held releases for one packet");

endmodule

>>> src/selective_repeat_receiver_crc16_unit.sv
// ============================================================================
// selective_repeat_receiver_crc16_unit
// Selective repeat ARQ receiver: CRC-16 check per packet, then ACK/NAK,
// in-order delivery and release of held successors.
// ----------------------------------------------------------------------------
// Input channel: one payload byte per beat with the packet's rx_crc and
// seq_num; last_byte marks the final byte. Bytes are taken one per cycle
// while the verdict queue (two packets deep) has room.
// Output channel: kind/out_seq/slot/last beats; last marks the final result
// of a packet. A packet yields one result, or two to five when it is the
// expected one (ACK, deliver, then up to three held releases).
// Result path: a packet's verdict is written into the queue, then the idle
// back end pops it and registers its first result; further results follow
// one per cycle while the output is not stalled. The back end takes no new
// verdict until it has loaded the last result of a packet.
// Output stall: the result register holds; the back end pauses, the queue
// fills and then the input side is stalled.
// Config: index 0 ahead_window, index 1 behind_window; write only when idle.
// Reset: CRC and expected sequence cleared, no slots held, windows 3 and 4.
// ============================================================================
module selective_repeat_receiver_crc16_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [srr_pkg::BYTE_W-1:0]     data_byte,
    input  logic [srr_pkg::CRC_W-1:0]      rx_crc,
    input  logic [srr_pkg::SEQ_BITS-1:0]   seq_num,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [srr_pkg::KIND_W-1:0]     kind,
    output logic [srr_pkg::SEQ_BITS-1:0]   out_seq,
    output logic [srr_pkg::SLOT_BITS-1:0]  slot,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srr_pkg::*;

    logic [AHEAD_W-1:0]  ahead_reg;
    logic [AHEAD_W-1:0]  ahead_next;
    logic [BEHIND_W-1:0] behind_reg;
    logic [BEHIND_W-1:0] behind_next;

    logic push;
    pkt_t push_pkt;
    logic q_full;
    logic q_valid;
    pkt_t q_pkt;
    logic pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        ahead_next  = ahead_reg;
        behind_next = behind_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_AHEAD:  ahead_next  = cfg_data[AHEAD_W-1:0];
                CFG_BEHIND: behind_next = cfg_data[BEHIND_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahead_reg  <= AHEAD_RESET;
            behind_reg <= BEHIND_RESET;
        end
        else
        begin
            ahead_reg  <= ahead_next;
            behind_reg <= behind_next;
        end
    end

    srr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .rx_crc    (rx_crc),
        .seq_num   (seq_num),
        .last_byte (last_byte),
        .push      (push),
        .push_pkt  (push_pkt),
        .q_full    (q_full)
    );

    srr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_pkt    (q_pkt)
    );

    srr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pkt         (q_pkt),
        .pop           (pop),
        .ahead_window  (ahead_reg),
        .behind_window (behind_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .out_seq       (out_seq),
        .slot          (slot),
        .last          (last)
    );

endmodule
